>>> src/framed_command_recognizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Framed command recognizer assertion macros
// Shared property shapes for the checker. Each expects clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECOGNIZER_UNIT_MACROS_SVH
`define FRAMED_COMMAND_RECOGNIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FCR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after reset has been applied.
`define FCR_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

>>> src/fcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command recognizer package
// Sizes, codes, command texts and the types shared by the front, queue and back.
// ----------------------------------------------------------------------------
package fcr_pkg;

   // Character buffer geometry.
   localparam int BUFFER_CHARS = 32;
   localparam int FILL_W       = $clog2(BUFFER_CHARS);
   localparam int FILL_EXT_W   = FILL_W + 1;

   // Only the leading characters can decide a command, so only those are kept.
   localparam int KEEP_CHARS  = 8;
   localparam int KEEP_IDX_W  = $clog2(KEEP_CHARS);
   localparam int TEXT_LEN_W  = KEEP_IDX_W + 1;
   localparam int NUM_CMDS    = 6;
   localparam int LENGTH_W    = 5;

   // Queue depths.
   localparam int EVQ_DEPTH   = 2;
   localparam int EVQ_PTR_W   = $clog2(EVQ_DEPTH);
   localparam int EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);
   localparam int OUTQ_DEPTH  = 2;
   localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

   typedef logic [7:0]                  char_type;
   typedef char_type [KEEP_CHARS-1:0]   text_type;
   typedef logic [FILL_W-1:0]           fill_type;
   typedef logic [TEXT_LEN_W-1:0]       text_len_type;
   typedef logic [2:0]                  cmd_code_type;
   typedef logic [0:0]                  csr_index_type;

   localparam fill_type FILL_LAST = fill_type'(BUFFER_CHARS - 1);

   // Control register indexes and reset values.
   localparam csr_index_type REG_START_MARKER = csr_index_type'(0);
   localparam csr_index_type REG_END_MARKER   = csr_index_type'(1);
   localparam char_type START_MARKER_RESET = 8'd60;
   localparam char_type END_MARKER_RESET   = 8'd62;

   // Command codes.
   localparam cmd_code_type CMD_NONE = 3'd0;
   localparam cmd_code_type CMD_LOFF = 3'd1;
   localparam cmd_code_type CMD_LON  = 3'd2;
   localparam cmd_code_type CMD_NW   = 3'd3;
   localparam cmd_code_type CMD_W    = 3'd4;
   localparam cmd_code_type CMD_AUT  = 3'd5;
   localparam cmd_code_type CMD_MAN  = 3'd6;

   // A closed frame as handed from the front to the back.
   typedef struct packed {
      text_type chars;
      fill_type length;
   } close_type;

   // One result transfer.
   typedef struct packed {
      cmd_code_type         command_code;
      logic [LENGTH_W-1:0]  frame_length;
   } result_type;

   // Queue status seen by the producer and the consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Command text, first character in element zero, unused elements zero.
   function automatic text_type cmd_text(input cmd_code_type code);
      text_type t;
      unique case (code)
         CMD_LOFF: t = '{8'h00, "D", "I", "+", "F", "F", "O", "L"};
         CMD_LON:  t = '{8'h00, 8'h00, "D", "I", "+", "N", "O", "L"};
         CMD_NW:   t = '{8'h00, 8'h00, 8'h00, "D", "I", "+", "W", "N"};
         CMD_W:    t = '{8'h00, 8'h00, 8'h00, 8'h00, "D", "I", "+", "W"};
         CMD_AUT:  t = '{8'h00, 8'h00, "D", "I", "+", "T", "U", "A"};
         CMD_MAN:  t = '{8'h00, 8'h00, "D", "I", "+", "N", "A", "M"};
         default:  t = '0;
      endcase
      return t;
   endfunction

   // Number of characters in each command text.
   function automatic text_len_type cmd_len(input cmd_code_type code);
      text_len_type n;
      unique case (code)
         CMD_LOFF: n = text_len_type'(7);
         CMD_LON:  n = text_len_type'(6);
         CMD_NW:   n = text_len_type'(5);
         CMD_W:    n = text_len_type'(4);
         CMD_AUT:  n = text_len_type'(6);
         CMD_MAN:  n = text_len_type'(6);
         default:  n = '0;
      endcase
      return n;
   endfunction

endpackage

>>> src/framed_command_recognizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command recognizer
// Recognizes framed text commands in a stream of received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on req_rx_byte; a transfer happens when req_push is high and
//   req_full is low. One byte can be taken in every cycle while req_full is low.
//   A start marker opens a frame, an end marker closes it and yields one result
//   (command code 1 to 6, or 0 for unknown text, plus the frame length, saturating at 31).
//   Results leave like a queue: while rsp_empty is low the oldest result is on
//   rsp_command_code and rsp_frame_length, and it is taken when rsp_pop is high.
//   A closed frame is first registered in the event queue; the compare logic
//   then reads it and loads the result queue, from which the result is offered.
//   The compare stage takes one frame a cycle while the result queue has room.
//   When results are not taken, the two-entry result queue and then the
//   two-entry event queue fill; req_full rises once the event queue is full.
//   The marker registers are written through csr_write_enable, csr_index and
//   csr_write_data and should only change while the block is idle.
//   Synchronous reset empties both queues, closes any open frame and sets the
//   markers to '<' and '>'.
// ----------------------------------------------------------------------------
module framed_command_recognizer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  fcr_pkg::char_type            req_rx_byte,
   output logic                         req_full,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output fcr_pkg::cmd_code_type        rsp_command_code,
   output logic [fcr_pkg::LENGTH_W-1:0] rsp_frame_length,
   input  logic                         csr_write_enable,
   input  fcr_pkg::csr_index_type       csr_index,
   input  fcr_pkg::char_type            csr_write_data
);
   import fcr_pkg::*;

   queue_status_type evq_status;
   logic             evq_push;
   logic             evq_pop;
   close_type        evq_in;
   close_type        evq_head;

   // Front end: markers, frame state and character storage.
   fcr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .evq_status       (evq_status),
      .evq_push         (evq_push),
      .evq_data         (evq_in)
   );

   // Closed frames waiting for the compare stage.
   fcr_event_queue u_event_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evq_push),
      .push_data (evq_in),
      .pop       (evq_pop),
      .head_data (evq_head),
      .status    (evq_status)
   );

   // Back end: text compare and result queue.
   fcr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .evq_status       (evq_status),
      .evq_data         (evq_head),
      .evq_pop          (evq_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_command_code (rsp_command_code),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

>>> src/fcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command recognizer front end
// Holds the markers, tracks the open frame, stores characters and hands each
// closed frame to the event queue.
// ----------------------------------------------------------------------------
module fcr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  fcr_pkg::char_type         req_rx_byte,
   output logic                      req_full,
   input  logic                      csr_write_enable,
   input  fcr_pkg::csr_index_type    csr_index,
   input  fcr_pkg::char_type         csr_write_data,
   input  fcr_pkg::queue_status_type evq_status,
   output logic                      evq_push,
   output fcr_pkg::close_type        evq_data
);
   import fcr_pkg::*;

   char_type start_marker_ff, start_marker_in;
   char_type end_marker_ff, end_marker_in;
   logic     open_ff, open_in;
   fill_type fill_ff, fill_in;
   text_type chars_ff, chars_in;

   logic accept;
   logic is_start;
   logic is_end;
   logic keep_slot;

   // A byte can only be taken while the event queue has room for a close.
   assign req_full = evq_status.full;
   assign accept   = req_push && !evq_status.full;

   // The start check wins when both markers hold the same value.
   assign is_start  = (req_rx_byte == start_marker_ff);
   assign is_end    = !is_start && (req_rx_byte == end_marker_ff);
   assign keep_slot = FILL_EXT_W'(fill_ff) < FILL_EXT_W'(KEEP_CHARS);

   // Control register writes.
   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_START_MARKER: start_marker_in = csr_write_data;
            REG_END_MARKER:   end_marker_in   = csr_write_data;
            default:          start_marker_in = start_marker_ff;
         endcase
      end
   end

   // Frame tracking and character storage.
   always_comb begin
      open_in  = open_ff;
      fill_in  = fill_ff;
      chars_in = chars_ff;
      if (accept) begin
         if (is_start) begin
            if (!open_ff) begin
               open_in = 1'b1;
               fill_in = '0;
            end
         end else if (is_end) begin
            if (open_ff) begin
               open_in = 1'b0;
               fill_in = '0;
            end
         end else if (open_ff) begin
            if (keep_slot) begin
               chars_in[fill_ff[KEEP_IDX_W-1:0]] = req_rx_byte;
            end
            // The fill position saturates on the last slot.
            fill_in = (fill_ff == FILL_LAST) ? FILL_LAST : fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
         open_ff         <= 1'b0;
         fill_ff         <= '0;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
         open_ff         <= open_in;
         fill_ff         <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   // An end marker inside a frame closes it and produces one event.
   assign evq_push       = accept && is_end && open_ff;
   assign evq_data.chars  = chars_ff;
   assign evq_data.length = fill_ff;

endmodule

>>> src/fcr_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command recognizer event queue
// Short queue of closed frames between the front end and the back end.
// ----------------------------------------------------------------------------
module fcr_event_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fcr_pkg::close_type        push_data,
   input  logic                      pop,
   output fcr_pkg::close_type        head_data,
   output fcr_pkg::queue_status_type status
);
   import fcr_pkg::*;

   close_type              entries_ff [EVQ_DEPTH];
   logic [EVQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [EVQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [EVQ_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == EVQ_CNT_W'(EVQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entries_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/fcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command recognizer back end
// Compares each closed frame with the command texts and queues the result.
// ----------------------------------------------------------------------------
module fcr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  fcr_pkg::queue_status_type evq_status,
   input  fcr_pkg::close_type        evq_data,
   output logic                      evq_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output fcr_pkg::cmd_code_type     rsp_command_code,
   output logic [fcr_pkg::LENGTH_W-1:0] rsp_frame_length
);
   import fcr_pkg::*;

   result_type              outq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0]   count_ff, count_in;

   logic                    out_full;
   logic                    do_read;
   text_len_type            limit;
   text_len_type            text_len;
   cmd_code_type            code;
   result_type              result;
   result_type              head;

   assign out_full  = (count_ff == OUTQ_CNT_W'(OUTQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign evq_pop   = !evq_status.empty && !out_full;
   assign do_read   = rsp_pop && !rsp_empty;

   // Characters that can count: the kept ones, up to the frame length.
   always_comb begin
      if (FILL_EXT_W'(evq_data.length) >= FILL_EXT_W'(KEEP_CHARS)) begin
         limit = text_len_type'(KEEP_CHARS);
      end else begin
         limit = text_len_type'(evq_data.length);
      end
   end

   // The compared text ends at the first stored zero.
   always_comb begin
      logic done;
      done     = 1'b0;
      text_len = '0;
      for (int i = 0; i < KEEP_CHARS; i++) begin
         if (!done && (text_len_type'(i) < limit) && (evq_data.chars[i] != 8'h00)) begin
            text_len = text_len_type'(i + 1);
         end else begin
            done = 1'b1;
         end
      end
   end

   // Match against every command; the lowest code wins.
   always_comb begin
      logic         hit;
      text_type     pattern;
      text_len_type plen;
      code = CMD_NONE;
      for (int k = NUM_CMDS; k >= 1; k--) begin
         pattern = cmd_text(cmd_code_type'(k));
         plen    = cmd_len(cmd_code_type'(k));
         hit     = (text_len == plen);
         for (int i = 0; i < KEEP_CHARS; i++) begin
            if ((text_len_type'(i) < plen) && (evq_data.chars[i] != pattern[i])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = cmd_code_type'(k);
         end
      end
   end

   assign result.command_code = code;
   assign result.frame_length = LENGTH_W'(evq_data.length);

   // Result queue bookkeeping.
   always_comb begin
      wr_ptr_in = evq_pop ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_read ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (evq_pop && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !evq_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evq_pop) begin
         outq_ff[wr_ptr_ff] <= result;
      end
   end

   // Oldest result on the ports.
   assign head             = outq_ff[rd_ptr_ff];
   assign rsp_command_code = head.command_code;
   assign rsp_frame_length = head.frame_length;

endmodule

>>> src/fcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command recognizer checker
// Port-level properties of the recognizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "framed_command_recognizer_unit_macros.svh"

module fcr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_pop,
   input logic                  rsp_empty,
   input fcr_pkg::cmd_code_type rsp_command_code
);
   import fcr_pkg::*;

   // Reset leaves nothing to deliver and room for new bytes.
   `FCR_ASSERT_AFTER_RESET(a_reset_empty, rsp_empty, "result waiting after reset")
   `FCR_ASSERT_AFTER_RESET(a_reset_not_full, !req_full, "input full after reset")

   // Only defined command codes are delivered.
   `FCR_ASSERT_SAME(a_code_range, !rsp_empty, rsp_command_code <= CMD_MAN, "bad command code")

   // A waiting result that is not taken stays available.
   `FCR_ASSERT_NEXT(a_result_held, !rsp_empty && !rsp_pop, !rsp_empty, "result lost")

endmodule

bind framed_command_recognizer_unit fcr_checker u_fcr_checker (.*);
